// ----- hdl/site_fst_dxy_accumulator_core_assert.svh -----
// Assertion macros used by the checker file of the accumulator core
`ifndef SITE_FST_DXY_ACCUMULATOR_CORE_ASSERT_SVH
`define SITE_FST_DXY_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SFDA_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SFDA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ----- hdl/sfda_pkg.sv -----
// Shared constants, types and helpers of the site Fst/Dxy accumulator
`timescale 1ns / 1ps
package sfda_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int FRAC_BITS   = 30;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int TOT_W   = CNT_W + 1;
    localparam int ALL_W   = CNT_W + 3;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int PROD_W  = 2 * Q_W;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = FRAC_BITS + ALL_W;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_MIN_PRESENT = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_MAF     = 2'd1;
    localparam logic [IDX_W-1:0] REG_STAT_MODE   = 2'd2;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_KEPT      = 3'd0,
        ST_NO_DATA   = 3'd1,
        ST_MISSING   = 3'd2,
        ST_MAF       = 3'd3,
        ST_MONO      = 3'd4,
        ST_MALFORMED = 3'd5
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0] min_present;
        logic [CFG_W-1:0] min_maf;
        logic             dxy_mode;
    } t_cfg;

    // Per-site counts handed from the front to the back, index 0/1 = population
    typedef struct packed {
        logic [1:0][CNT_W-1:0] pres;
        logic [1:0][CNT_W-1:0] mis;
        logic [1:0][ALL_W-1:0] alleles;
        logic [1:0][ALL_W-1:0] alt;
        logic                  malformed;
    } t_site;

    function automatic logic ploidy_ok(input logic [3:0] pl);
        logic ok;
        case (pl)
            4'd2, 4'd4, 4'd6, 4'd8: ok = 1'b1;
            default:                ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ----- hdl/sfda_front.sv -----
// Front end: accepts calls, keeps per-site counts and emits one site record
`timescale 1ns / 1ps
module sfda_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_population,
    input  logic          i_missing_call,
    input  logic [3:0]    i_ploidy,
    input  logic [3:0]    i_alt_count,
    input  logic          i_site_last,
    input  logic          i_q_full,
    output logic          o_push,
    output sfda_pkg::t_site o_site
);
    import sfda_pkg::*;

    logic [1:0][CNT_W-1:0] r_pres, n_pres, r_mis, n_mis;
    logic [1:0][ALL_W-1:0] r_all, n_all, r_alt, n_alt;
    logic                  r_malf, n_malf;
    logic [TOT_W-1:0]      tot;
    logic                  accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign tot     = TOT_W'(r_pres[i_population]) + TOT_W'(r_mis[i_population]);

    // Classify the call and update its population's counts
    always_comb begin
        n_pres = r_pres;
        n_mis  = r_mis;
        n_all  = r_all;
        n_alt  = r_alt;
        n_malf = r_malf;
        if (tot >= TOT_W'(MAX_SAMPLES)) begin
            n_malf = 1'b1;
        end else if (i_missing_call) begin
            n_mis[i_population] = r_mis[i_population] + CNT_W'(1);
        end else if (!ploidy_ok(i_ploidy) || (i_alt_count > i_ploidy)) begin
            n_malf = 1'b1;
        end else begin
            n_pres[i_population] = r_pres[i_population] + CNT_W'(1);
            n_all[i_population]  = r_all[i_population] + ALL_W'(i_ploidy);
            n_alt[i_population]  = r_alt[i_population] + ALL_W'(i_alt_count);
        end
    end

    assign o_push              = accept && i_site_last;
    assign o_site.pres         = n_pres;
    assign o_site.mis          = n_mis;
    assign o_site.alleles      = n_all;
    assign o_site.alt          = n_alt;
    assign o_site.malformed    = n_malf;

    // Hold counts, clear them at the site end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_site_last)) begin
            r_pres <= '0;
            r_mis  <= '0;
            r_all  <= '0;
            r_alt  <= '0;
            r_malf <= 1'b0;
        end else if (accept) begin
            r_pres <= n_pres;
            r_mis  <= n_mis;
            r_all  <= n_all;
            r_alt  <= n_alt;
            r_malf <= n_malf;
        end
    end

endmodule

// ----- hdl/sfda_queue.sv -----
// Two-entry queue of site records between front and back
`timescale 1ns / 1ps
module sfda_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sfda_pkg::t_site i_site,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nonempty,
    output sfda_pkg::t_site o_site
);
    import sfda_pkg::*;

    t_site      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_site     = r_mem[r_rd];

    // Store pushed records
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_site;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ----- hdl/sfda_div.sv -----
// Iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sfda_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sfda_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [sfda_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [sfda_pkg::Q_W-1:0]       o_quo
);
    import sfda_pkg::*;

    localparam int CW = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den, r_rem, n_rem;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy, r_done, qbit;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
        qbit   = (rem_sh >= {1'b0, r_den});
        n_rem  = qbit ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
    end

    assign o_done = r_done;
    assign o_quo  = r_num[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(DIV_NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[DIV_NUM_W-2:0], qbit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/sfda_back.sv -----
// Back end: filters a site, computes hw and hb and updates running totals
`timescale 1ns / 1ps
module sfda_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfda_pkg::t_cfg  i_cfg,
    input  logic            i_q_nonempty,
    input  sfda_pkg::t_site i_site,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_site_status,
    output logic signed [31:0] o_within_term,
    output logic [30:0]     o_between_term,
    output logic signed [63:0] o_total_within,
    output logic [61:0]     o_total_between,
    output logic [31:0]     o_kept_sites
);
    import sfda_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_CMP, S_JUDGE, S_DP1, S_DP2, S_MQ1, S_DS1, S_WS1,
        S_MQ2, S_DS2, S_WS2, S_MD, S_T0, S_MB1, S_MB1A, S_MB2, S_HB, S_ACC, S_EMIT
    } t_state;

    t_state              r_state;
    t_site               r_site;
    logic [1:0]          r_step;
    logic [3:0]          r_fail;
    t_status             r_status, n_status;
    logic [Q_W-1:0]      r_p1, r_p2, r_t0, r_t1, r_t2;
    logic [Q_W-1:0]      mul_a, mul_b, q1, q2, dif;
    logic [PROD_W-1:0]   r_prod, r_acc;
    logic signed [31:0]  r_hw;
    logic [30:0]         r_hb;
    logic signed [63:0]  r_sum_w, n_sum_w;
    logic [61:0]         r_sum_b;
    logic [62:0]         n_sum_b;
    logic [31:0]         r_kept;
    logic                ovf_w;
    logic                pop_sel, chk_fail;
    logic [ALL_W-1:0]    m1, m2, den1, den2;
    logic                div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [Q_W-1:0]      div_quo;
    logic [PROD_W:0]     t0_sum;
    logic [PROD_W:0]     hb_sum;

    assign q1  = Q_ONE - r_p1;
    assign q2  = Q_ONE - r_p2;
    assign dif = (r_p1 >= r_p2) ? (r_p1 - r_p2) : (r_p2 - r_p1);
    assign pop_sel = r_step[0];
    assign den1 = (r_site.alleles[0] != '0) ? r_site.alleles[0] : ALL_W'(1);
    assign den2 = (r_site.alleles[1] != '0) ? r_site.alleles[1] : ALL_W'(1);
    assign m1   = (r_site.alleles[0] > ALL_W'(1)) ? (r_site.alleles[0] - ALL_W'(1))
                                                  : ALL_W'(1);
    assign m2   = (r_site.alleles[1] > ALL_W'(1)) ? (r_site.alleles[1] - ALL_W'(1))
                                                  : ALL_W'(1);

    // Pick the multiplier operands for this step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_CHK: begin
                if (r_step[1]) begin
                    mul_a = Q_W'(i_cfg.min_maf);
                    mul_b = Q_W'(r_site.alleles[pop_sel]);
                end else begin
                    mul_a = Q_W'(i_cfg.min_present);
                    mul_b = Q_W'(r_site.pres[pop_sel]) + Q_W'(r_site.mis[pop_sel]);
                end
            end
            S_MQ1: begin mul_a = r_p1; mul_b = q1; end
            S_MQ2: begin mul_a = r_p2; mul_b = q2; end
            S_MD:  begin mul_a = dif;  mul_b = dif; end
            S_MB1: begin mul_a = r_p1; mul_b = q2; end
            S_MB2: begin mul_a = r_p2; mul_b = q1; end
            default: ;
        endcase
    end

    // Compare the product against the scaled count of this check
    always_comb begin
        if (r_step[1]) begin
            chk_fail = (PROD_W'({r_site.alt[pop_sel], 16'b0}) < r_prod) ||
                       (PROD_W'({r_site.alleles[pop_sel] - r_site.alt[pop_sel], 16'b0})
                        < r_prod);
        end else begin
            chk_fail = PROD_W'({r_site.pres[pop_sel], 16'b0}) < r_prod;
        end
    end

    // Judge the site in filter order
    always_comb begin
        if (r_site.malformed) begin
            n_status = ST_MALFORMED;
        end else if (r_site.pres[0] == '0 || r_site.pres[1] == '0) begin
            n_status = ST_NO_DATA;
        end else if (r_fail[0] || r_fail[1]) begin
            n_status = ST_MISSING;
        end else if (r_fail[2] || r_fail[3]) begin
            n_status = ST_MAF;
        end else if (!i_cfg.dxy_mode && r_site.alt[0] == '0 && r_site.alt[1] == '0) begin
            n_status = ST_MONO;
        end else begin
            n_status = ST_KEPT;
        end
    end

    // Start and feed the shared divider
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            S_JUDGE: begin
                div_start = (n_status == ST_KEPT);
                div_num   = (DIV_NUM_W'(r_site.alt[0]) << FRAC_BITS) + DIV_NUM_W'(den1 >> 1);
                div_den   = DIV_DEN_W'(den1);
            end
            S_DP1: begin
                div_start = div_done;
                div_num   = (DIV_NUM_W'(r_site.alt[1]) << FRAC_BITS) + DIV_NUM_W'(den2 >> 1);
                div_den   = DIV_DEN_W'(den2);
            end
            S_DS1: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(r_prod) + (DIV_NUM_W'(m1) << (FRAC_BITS - 1));
                div_den   = DIV_DEN_W'(m1) << FRAC_BITS;
            end
            S_DS2: begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(r_prod) + (DIV_NUM_W'(m2) << (FRAC_BITS - 1));
                div_den   = DIV_DEN_W'(m2) << FRAC_BITS;
            end
            default: ;
        endcase
    end

    sfda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Rounding and saturating accumulation
    assign t0_sum  = {1'b0, r_prod} + (PROD_W+1)'(Q_ONE >> 1);
    assign hb_sum  = {1'b0, r_acc} + {1'b0, r_prod} + (PROD_W+1)'(Q_ONE >> 1);
    assign n_sum_w = r_sum_w + 64'(r_hw);
    assign ovf_w   = (r_sum_w[63] == r_hw[31]) && (n_sum_w[63] != r_sum_w[63]);
    assign n_sum_b = {1'b0, r_sum_b} + 63'(r_hb);

    assign o_pop = (r_state == S_IDLE) && i_q_nonempty;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mul_a * mul_b);
    end

    // Sequencer with its registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum_w <= '0;
            r_sum_b <= '0;
            r_kept  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && (r_state != S_EMIT)) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_nonempty) begin
                        r_site  <= i_site;
                        r_step  <= 2'd0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: r_state <= S_CMP;
                S_CMP: begin
                    r_fail[r_step] <= chk_fail;
                    r_step         <= r_step + 2'd1;
                    r_state        <= (r_step == 2'd3) ? S_JUDGE : S_CHK;
                end
                S_JUDGE: begin
                    r_status <= n_status;
                    r_hw     <= '0;
                    r_hb     <= '0;
                    r_state  <= (n_status == ST_KEPT) ? S_DP1 : S_EMIT;
                end
                S_DP1: begin
                    if (div_done) begin
                        r_p1    <= div_quo;
                        r_state <= S_DP2;
                    end
                end
                S_DP2: begin
                    if (div_done) begin
                        r_p2    <= div_quo;
                        r_state <= S_MQ1;
                    end
                end
                S_MQ1: r_state <= S_DS1;
                S_DS1: r_state <= S_WS1;
                S_WS1: begin
                    if (div_done) begin
                        r_t1    <= div_quo;
                        r_state <= S_MQ2;
                    end
                end
                S_MQ2: r_state <= S_DS2;
                S_DS2: r_state <= S_WS2;
                S_WS2: begin
                    if (div_done) begin
                        r_t2    <= div_quo;
                        r_state <= S_MD;
                    end
                end
                S_MD: r_state <= S_T0;
                S_T0: begin
                    r_t0    <= t0_sum[FRAC_BITS +: Q_W];
                    r_state <= S_MB1;
                end
                S_MB1:  r_state <= S_MB1A;
                S_MB1A: begin
                    r_acc   <= r_prod;
                    r_state <= S_MB2;
                end
                S_MB2: r_state <= S_HB;
                S_HB: begin
                    r_hb    <= 31'(hb_sum[FRAC_BITS +: Q_W]);
                    r_hw    <= 32'({1'b0, r_t0}) - 32'({1'b0, r_t1}) - 32'({1'b0, r_t2});
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (ovf_w) begin
                        r_sum_w <= r_sum_w[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                    end else begin
                        r_sum_w <= n_sum_w;
                    end
                    r_sum_b <= n_sum_b[62] ? {62{1'b1}} : n_sum_b[61:0];
                    if (r_kept != '1) r_kept <= r_kept + 32'd1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!o_valid || i_ready) begin
                        o_valid         <= 1'b1;
                        o_site_status   <= r_status;
                        o_within_term   <= r_hw;
                        o_between_term  <= r_hb;
                        o_total_within  <= r_sum_w;
                        o_total_between <= r_sum_b;
                        o_kept_sites    <= r_kept;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/site_fst_dxy_accumulator_core.sv -----
// Top level of the site Fst/Dxy accumulator: front, site queue, back, config
// Calls are accepted one per cycle; a site holds the front only when two
// finished sites already wait in the queue. A kept site runs four 64-step
// divisions on the shared restoring divider in the back; a dropped site skips
// them. Results can stall on the output. Reset (synchronous,
// active low) clears all counts, totals and configuration registers to zero.
`timescale 1ns / 1ps
module site_fst_dxy_accumulator_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_population,
    input  logic                    i_missing_call,
    input  logic [3:0]              i_ploidy,
    input  logic [3:0]              i_alt_count,
    input  logic                    i_site_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2:0]              o_site_status,
    output logic signed [31:0]      o_within_term,
    output logic [30:0]             o_between_term,
    output logic signed [63:0]      o_total_within,
    output logic [61:0]             o_total_between,
    output logic [31:0]             o_kept_sites,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [sfda_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [sfda_pkg::CFG_W-1:0] i_cfg_data
);
    import sfda_pkg::*;

    t_cfg  r_cfg;
    t_site front_site, q_site;
    logic  push, q_full, q_nonempty, pop;

    assign o_cfg_ready = 1'b1;

    // Write configuration requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_PRESENT: r_cfg.min_present <= i_cfg_data;
                REG_MIN_MAF:     r_cfg.min_maf     <= i_cfg_data;
                REG_STAT_MODE:   r_cfg.dxy_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sfda_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_population   (i_population),
        .i_missing_call (i_missing_call),
        .i_ploidy       (i_ploidy),
        .i_alt_count    (i_alt_count),
        .i_site_last    (i_site_last),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_site         (front_site)
    );

    sfda_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_site     (front_site),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_site     (q_site)
    );

    sfda_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_nonempty    (q_nonempty),
        .i_site          (q_site),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_site_status   (o_site_status),
        .o_within_term   (o_within_term),
        .o_between_term  (o_between_term),
        .o_total_within  (o_total_within),
        .o_total_between (o_total_between),
        .o_kept_sites    (o_kept_sites)
    );

endmodule

// ----- hdl/sfda_checker.sv -----
// Port-level checker of the accumulator core and its bind
`timescale 1ns / 1ps
`include "site_fst_dxy_accumulator_core_assert.svh"
module sfda_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_site_status,
    input logic [31:0] o_within_term,
    input logic [30:0] o_between_term,
    input logic [31:0] o_kept_sites
);
    import sfda_pkg::*;

    `SFDA_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_valid, o_site_status <= ST_MALFORMED, "site status out of range")
    `SFDA_ASSERT_IMPL(a_drop_zero, i_clk, i_rst_n, o_valid && (o_site_status != ST_KEPT), (o_within_term == '0) && (o_between_term == '0), "dropped site carries nonzero terms")
    `SFDA_ASSERT_IMPL(a_kept_count, i_clk, i_rst_n, o_valid && (o_site_status == ST_KEPT), o_kept_sites != '0, "kept site with zero kept count")
    `SFDA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_kept_sites), "stalled result changed")

endmodule

bind site_fst_dxy_accumulator_core sfda_checker u_sfda_checker (.*);
